### hdl/cfr_pkg.sv
// Shared constants and controller/datapath handshake types for the
// checksummed frame receiver. No dependencies.
package cfr_pkg;

  localparam int MAX_CHANNEL_BYTES   = 16;
  localparam int MAX_PAYLOAD_BYTES   = 32;
  localparam int MAX_FRAME_BYTES_DEF = 56;

  // Byte offsets within a frame
  localparam int HDR_BYTES = 7;   // sync(2) ver type seq clen plen

  localparam logic [7:0] SYNC_A        = 8'h45;
  localparam logic [7:0] SYNC_B        = 8'h42;
  localparam logic [7:0] PROTO_VERSION = 8'h01;

  localparam logic [7:0] KIND_TEXT      = 8'h01;
  localparam logic [7:0] KIND_NUMBER    = 8'h02;
  localparam logic [7:0] KIND_BOOLEAN   = 8'h03;
  localparam logic [7:0] KIND_ACK       = 8'h80;
  localparam logic [7:0] KIND_HELLO     = 8'h81;
  localparam logic [7:0] KIND_HELLO_ACK = 8'h82;
  localparam logic [7:0] KIND_PING      = 8'h83;
  localparam logic [7:0] KIND_PONG      = 8'h84;

  localparam logic [1:0] REPLY_NONE      = 2'd0;
  localparam logic [1:0] REPLY_ACK       = 2'd1;
  localparam logic [1:0] REPLY_PONG      = 2'd2;
  localparam logic [1:0] REPLY_HELLO_ACK = 2'd3;

  localparam logic [1:0] PART_HEADER  = 2'd0;
  localparam logic [1:0] PART_CHANNEL = 2'd1;
  localparam logic [1:0] PART_PAYLOAD = 2'd2;

  // Controller -> datapath
  typedef struct packed {
    logic take_byte;   // input word accepted this cycle
    logic rd_issue;    // read frame store at stream pointer
    logic load_data;   // move read data into the output register
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic hdr_stream;  // accepted word completes a frame with data to stream
    logic stream_last; // stream pointer sits on the final data byte
    logic slot_free;   // output register empty or being drained
  } dp_status_t;

endpackage

### hdl/cfr_if.sv
// Valid/ready channel interfaces for received bytes and result items.
// Depends on nothing.
interface cfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] reply_kind;
  logic [7:0] ack_sequence;
  logic [7:0] frame_type;
  logic       is_new_data;
  logic       session_reset;
  logic [1:0] part_kind;
  logic [7:0] data_byte;
  logic [4:0] byte_index;
  logic       last_item;

  modport source (output valid, output reply_kind, output ack_sequence,
                  output frame_type, output is_new_data, output session_reset,
                  output part_kind, output data_byte, output byte_index,
                  output last_item, input ready);
  modport sink   (input valid, input reply_kind, input ack_sequence,
                  input frame_type, input is_new_data, input session_reset,
                  input part_kind, input data_byte, input byte_index,
                  input last_item, output ready);
endinterface

### hdl/checksummed_frame_receiver_top.sv
// Top level of the checksummed frame receiver.
// Uses cfr_pkg, cfr_if, cfr_ctrl and cfr_datapath.
//
// Receives link bytes one word per cycle on rx, hunts for the 0x45 0x42 sync
// pair, collects version, type, sequence, channel length, payload length,
// channel, payload and an XOR checksum (over version through payload), and
// classifies good frames. Ping yields a pong header, hello a hello-ack header
// with session_reset, hello-ack a header with session_reset only. Text,
// number and boolean frames get an ack header; a new sequence also streams
// its channel bytes and then payload bytes as further result words, with
// last_item on the final word. Rate: one rx word per cycle while collecting,
// as long as the output register is empty or drained in that cycle; any rx
// word waits while a result word sits unaccepted. A frame with data streams
// out each channel/payload byte with a frame store read, then an output
// load, and rx stays blocked until the last data byte is loaded, longer
// under result backpressure. The frame store needs no clearing after reset.
module checksummed_frame_receiver_top
  import cfr_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input logic          clk,
  input logic          rst,
  cfr_rx_if.sink       rx,
  cfr_result_if.source result
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  cfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .status   (status),
    .cmd      (cmd)
  );

  cfr_datapath #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .rx_byte       (rx.rx_byte),
    .out_ready     (result.ready),
    .out_valid     (result.valid),
    .reply_kind    (result.reply_kind),
    .ack_sequence  (result.ack_sequence),
    .frame_type    (result.frame_type),
    .is_new_data   (result.is_new_data),
    .session_reset (result.session_reset),
    .part_kind     (result.part_kind),
    .data_byte     (result.data_byte),
    .byte_index    (result.byte_index),
    .last_item     (result.last_item)
  );

endmodule

### hdl/cfr_datapath.sv
// Datapath: hunt counter, header capture, running XOR, frame store,
// frame classification and the output register. Uses cfr_pkg.
module cfr_datapath
  import cfr_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  input  logic [7:0] rx_byte,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [1:0] reply_kind,
  output logic [7:0] ack_sequence,
  output logic [7:0] frame_type,
  output logic       is_new_data,
  output logic       session_reset,
  output logic [1:0] part_kind,
  output logic [7:0] data_byte,
  output logic [4:0] byte_index,
  output logic       last_item
);

  localparam int FILL_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);

  logic [7:0] frame_store [MAX_FRAME_BYTES];

  logic [FILL_W-1:0] fill;
  logic [7:0]        version, ftype, seq, clen, plen, bool_val, xsum, last_seq;
  logic [ADDR_W-1:0] cnt;
  logic [7:0]        rd_data;

  logic [FILL_W-1:0] fill_next;
  logic              in_body, full, bad_len, frame_done, sum_ok;
  logic              is_data, data_ok, is_repeat, hdr_emit;
  logic [7:0]        plen_eff;
  logic [8:0]        data_total;
  logic [9:0]        frame_len;
  logic [8:0]        pay_index;
  logic              in_chan;

  assign full      = fill >= FILL_W'(MAX_FRAME_BYTES);
  assign in_body   = (fill >= FILL_W'(2)) && !full;
  assign fill_next = fill + FILL_W'(1);
  assign plen_eff  = (fill == FILL_W'(HDR_BYTES - 1)) ? rx_byte : plen;
  assign bad_len   = ({1'b0, clen} > 9'(MAX_CHANNEL_BYTES)) ||
                     ({1'b0, plen_eff} > 9'(MAX_PAYLOAD_BYTES));
  assign frame_len = 10'(HDR_BYTES + 1) + 10'(clen) + 10'(plen);
  assign frame_done = in_body && (fill_next >= FILL_W'(HDR_BYTES)) && !bad_len &&
                      (10'(fill_next) == frame_len);

  // Checksum byte XORed in: good frame folds to zero
  assign sum_ok = (version == PROTO_VERSION) && ((xsum ^ rx_byte) == 8'h00);

  assign is_data = (ftype == KIND_TEXT) || (ftype == KIND_NUMBER) ||
                   (ftype == KIND_BOOLEAN);
  assign data_ok = is_data && (seq != 8'h00) &&
                   !((ftype == KIND_NUMBER) && (plen != 8'd4)) &&
                   !((ftype == KIND_BOOLEAN) && (plen != 8'd1)) &&
                   !((ftype == KIND_BOOLEAN) && (bool_val > 8'd1));
  assign is_repeat = seq == last_seq;
  assign hdr_emit  = frame_done && sum_ok &&
                     ((ftype == KIND_PING) || (ftype == KIND_HELLO) ||
                      (ftype == KIND_HELLO_ACK) || data_ok);

  assign data_total = 9'(clen) + 9'(plen);
  assign in_chan    = 9'(cnt) < 9'(clen);
  assign pay_index  = in_chan ? 9'(cnt) : 9'(cnt) - 9'(clen);

  assign status.hdr_stream  = frame_done && sum_ok && data_ok && !is_repeat &&
                              (data_total != 9'd0);
  assign status.stream_last = 9'(cnt) == data_total - 9'd1;
  assign status.slot_free   = !out_valid || out_ready;

  // Hunt / collect counter and session sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      last_seq <= '0;
    end else if (cmd.take_byte) begin
      if (fill == FILL_W'(0) || full) begin
        fill <= (rx_byte == SYNC_A) ? FILL_W'(1) : FILL_W'(0);
      end else if (fill == FILL_W'(1)) begin
        if (rx_byte == SYNC_B) begin
          fill <= FILL_W'(2);
        end else if (rx_byte != SYNC_A) begin
          fill <= '0;
        end
      end else if (fill_next < FILL_W'(HDR_BYTES)) begin
        fill <= fill_next;
      end else if (bad_len) begin
        fill <= (rx_byte == SYNC_A) ? FILL_W'(1) : FILL_W'(0);
      end else if (frame_done) begin
        fill <= '0;
        if (sum_ok) begin
          if (ftype == KIND_HELLO || ftype == KIND_HELLO_ACK) begin
            last_seq <= '0;
          end else if (data_ok && !is_repeat) begin
            last_seq <= seq;
          end
        end
      end else begin
        fill <= fill_next;
      end
    end
  end

  // Header capture and running checksum
  always_ff @(posedge clk) begin
    if (cmd.take_byte && in_body) begin
      xsum <= (fill == FILL_W'(2)) ? rx_byte : (xsum ^ rx_byte);
      case (fill)
        FILL_W'(2): version <= rx_byte;
        FILL_W'(3): ftype   <= rx_byte;
        FILL_W'(4): seq     <= rx_byte;
        FILL_W'(5): clen    <= rx_byte;
        FILL_W'(6): plen    <= rx_byte;
        default: ;
      endcase
      if ((fill >= FILL_W'(HDR_BYTES)) &&
          (10'(fill) == 10'(HDR_BYTES) + 10'(clen))) begin
        bool_val <= rx_byte;
      end
    end
  end

  // Frame store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.take_byte && in_body) begin
      frame_store[fill[ADDR_W-1:0]] <= rx_byte;
    end
    if (cmd.rd_issue) begin
      rd_data <= frame_store[ADDR_W'(HDR_BYTES) + cnt];
    end
  end

  // Stream pointer
  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      cnt <= '0;
    end else if (cmd.load_data) begin
      cnt <= cnt + ADDR_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.take_byte && hdr_emit) || cmd.load_data) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.take_byte && hdr_emit) begin
      frame_type    <= ftype;
      part_kind     <= PART_HEADER;
      data_byte     <= 8'h00;
      byte_index    <= '0;
      ack_sequence  <= 8'h00;
      is_new_data   <= 1'b0;
      session_reset <= 1'b0;
      last_item     <= 1'b1;
      case (ftype)
        KIND_PING: reply_kind <= REPLY_PONG;
        KIND_HELLO: begin
          reply_kind    <= REPLY_HELLO_ACK;
          session_reset <= 1'b1;
        end
        KIND_HELLO_ACK: begin
          reply_kind    <= REPLY_NONE;
          session_reset <= 1'b1;
        end
        default: begin
          reply_kind   <= REPLY_ACK;
          ack_sequence <= seq;
          is_new_data  <= !is_repeat;
          last_item    <= is_repeat || (data_total == 9'd0);
        end
      endcase
    end else if (cmd.load_data) begin
      reply_kind    <= REPLY_NONE;
      ack_sequence  <= 8'h00;
      is_new_data   <= 1'b1;
      session_reset <= 1'b0;
      part_kind     <= in_chan ? PART_CHANNEL : PART_PAYLOAD;
      data_byte     <= rd_data;
      byte_index    <= pay_index[4:0];
      last_item     <= status.stream_last;
    end
  end

endmodule

### hdl/cfr_ctrl.sv
// Controller: sequences byte intake and the channel/payload stream-out.
// Uses cfr_pkg.
module cfr_ctrl
  import cfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_READ,
    ST_WRITE
  } state_t;

  state_t state;

  assign in_ready      = (state == ST_COLLECT) && status.slot_free;
  assign cmd.take_byte = in_valid && in_ready;
  assign cmd.rd_issue  = state == ST_READ;
  assign cmd.load_data = (state == ST_WRITE) && status.slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      case (state)
        ST_COLLECT: begin
          if (cmd.take_byte && status.hdr_stream) state <= ST_READ;
        end
        ST_READ: state <= ST_WRITE;
        ST_WRITE: begin
          if (cmd.load_data) state <= status.stream_last ? ST_COLLECT : ST_READ;
        end
        default: state <= ST_COLLECT;
      endcase
    end
  end

endmodule
